FILE: hdl/rjsc_pkg.sv
// shared types and constants of the row jitter shift corrector
package rjsc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int PIX_BITS    = 3 * SAMPLE_BITS;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = COL_BITS + 1;
    localparam int ADDR_BITS   = COL_BITS + 1;
    localparam int JIT_BITS    = 11;
    localparam int SYNC_BITS   = 6;
    localparam int SHIFT_BITS  = JIT_BITS + 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_JITTER  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_ALL   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHROMA_FILL = 3'd5;

    // reset values of the registers
    localparam logic [WIDTH_BITS-1:0]  RST_ROW_WIDTH   = 13'd1920;
    localparam logic [JIT_BITS-1:0]    RST_MAX_JITTER  = 11'd40;
    localparam logic [SYNC_BITS-1:0]   RST_SYNC_WIDTH  = 6'd20;
    localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD   = 16'd20;
    localparam logic [SAMPLE_BITS-1:0] RST_CHROMA_FILL = 16'd127;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  row_width;
        logic [JIT_BITS-1:0]    max_jitter;
        logic [SYNC_BITS-1:0]   sync_width;
        logic [SAMPLE_BITS-1:0] threshold;
        logic                   check_all_planes;
        logic [SAMPLE_BITS-1:0] chroma_fill;
    } cfg_t;

    // per-item result control decided by the front part
    typedef struct packed {
        logic px_valid;
        logic from_store;
        logic last;
    } res_ctrl_t;

    typedef struct packed {
        res_ctrl_t           ctrl;
        logic [PIX_BITS-1:0] pix;
    } q_entry_t;

endpackage

FILE: hdl/rjsc_ram.sv
// generic simple dual-port ram with registered read
module rjsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

FILE: hdl/rjsc_front.sv
// front part: row tracking, start detection, line store access
module rjsc_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rjsc_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]  plane0_in,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]  plane1_in,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]  plane2_in,
    input  logic [rjsc_pkg::QCNT_BITS-1:0]    q_count,
    output logic                              push,
    output rjsc_pkg::q_entry_t                push_entry
);
    import rjsc_pkg::*;

    logic [COL_BITS-1:0]   column_reg, column_next;
    logic                  write_bank_reg, write_bank_next;
    logic [JIT_BITS-1:0]   first_hit_reg [3];
    logic [JIT_BITS-1:0]   first_hit_next [3];
    logic [2:0]            hit_seen_reg, hit_seen_next;
    logic [SHIFT_BITS-1:0] ready_shift_reg, ready_shift_next;
    logic                  row_ready_reg, row_ready_next;
    logic                  s1_valid_reg;
    res_ctrl_t             s1_ctrl_reg, ctrl_next;

    logic                  fire;
    logic                  is_pixel;
    logic [WIDTH_BITS-1:0] eff_w;
    logic [WIDTH_BITS-1:0] col_ext;
    logic                  row_end;
    logic                  col_in_row;
    logic [WIDTH_BITS-1:0] src_col;
    logic [SAMPLE_BITS-1:0] smp [3];
    logic [JIT_BITS-1:0]   max_ab, max_hit;
    logic [SHIFT_BITS-1:0] row_shift;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [PIX_BITS-1:0]   rd_data;

    // credit check: items in flight never exceed the queue depth
    assign in_ready = (q_count + QCNT_BITS'(s1_valid_reg)) < QCNT_BITS'(QUEUE_DEPTH);
    assign fire     = in_valid && in_ready;
    assign is_pixel = (func == 1'b0);

    // effective row width clamped to 1..MAX_WIDTH
    always_comb
    begin
        if (cfg.row_width == '0)
        begin
            eff_w = WIDTH_BITS'(1);
        end
        else if (cfg.row_width > WIDTH_BITS'(MAX_WIDTH))
        begin
            eff_w = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_w = cfg.row_width;
        end
    end

    assign col_ext    = {1'b0, column_reg};
    assign row_end    = col_ext >= (eff_w - WIDTH_BITS'(1));
    assign col_in_row = col_ext < eff_w;
    assign src_col    = col_ext + WIDTH_BITS'(ready_shift_reg);

    // result control for this item
    always_comb
    begin
        ctrl_next.px_valid   = row_ready_reg && col_in_row;
        ctrl_next.from_store = src_col < eff_w;
        ctrl_next.last       = row_ready_reg && col_in_row && row_end;
    end

    assign smp[0] = plane0_in;
    assign smp[1] = plane1_in;
    assign smp[2] = plane2_in;

    // per-plane first-hit detection
    always_comb
    begin
        hit_seen_next = hit_seen_reg;
        for (int p = 0; p < 3; p++)
        begin
            first_hit_next[p] = first_hit_reg[p];
            if (is_pixel && col_in_row && (p == 0 || cfg.check_all_planes)
                && !hit_seen_reg[p] && (col_ext < {2'b00, cfg.max_jitter})
                && (smp[p] >= cfg.threshold))
            begin
                first_hit_next[p] = column_reg[JIT_BITS-1:0];
                hit_seen_next[p]  = 1'b1;
            end
        end
    end

    // row shift: latest hit among the planes, plus sync width when that hit is nonzero
    always_comb
    begin
        max_ab  = (first_hit_next[1] > first_hit_next[0]) ? first_hit_next[1]
                                                         : first_hit_next[0];
        max_hit = (first_hit_next[2] > max_ab) ? first_hit_next[2] : max_ab;
        if (max_hit != '0)
        begin
            row_shift = {1'b0, max_hit} + SHIFT_BITS'(cfg.sync_width);
        end
        else
        begin
            row_shift = '0;
        end
    end

    // row state update
    always_comb
    begin
        column_next      = column_reg + COL_BITS'(1);
        write_bank_next  = write_bank_reg;
        ready_shift_next = ready_shift_reg;
        row_ready_next   = row_ready_reg;
        if (row_end)
        begin
            column_next = '0;
            if (is_pixel)
            begin
                ready_shift_next = row_shift;
                row_ready_next   = 1'b1;
                write_bank_next  = ~write_bank_reg;
            end
            else
            begin
                ready_shift_next = '0;
                row_ready_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            write_bank_reg  <= 1'b0;
            hit_seen_reg    <= '0;
            ready_shift_reg <= '0;
            row_ready_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            for (int p = 0; p < 3; p++)
            begin
                first_hit_reg[p] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= fire;
            if (fire)
            begin
                column_reg      <= column_next;
                write_bank_reg  <= write_bank_next;
                ready_shift_reg <= ready_shift_next;
                row_ready_reg   <= row_ready_next;
                if (row_end)
                begin
                    hit_seen_reg <= '0;
                    for (int p = 0; p < 3; p++)
                    begin
                        first_hit_reg[p] <= '0;
                    end
                end
                else
                begin
                    hit_seen_reg <= hit_seen_next;
                    for (int p = 0; p < 3; p++)
                    begin
                        first_hit_reg[p] <= first_hit_next[p];
                    end
                end
            end
        end
    end

    // control rides alongside the store read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_ctrl_reg <= ctrl_next;
        end
    end

    // line store: write into the filling bank, read from the finished bank
    assign wr_en   = fire && is_pixel && col_in_row;
    assign wr_addr = {write_bank_reg, column_reg};
    assign rd_addr = {~write_bank_reg, src_col[COL_BITS-1:0]};

    rjsc_ram #(
        .WIDTH(PIX_BITS),
        .DEPTH(2 * MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({plane2_in, plane1_in, plane0_in}),
        .re    (fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign push            = s1_valid_reg;
    assign push_entry.ctrl = s1_ctrl_reg;
    assign push_entry.pix  = rd_data;

    // checks
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr[ADDR_BITS-1] != rd_addr[ADDR_BITS-1])
        else $error("line store read and write hit the same bank");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && row_end |=> column_reg == '0 && hit_seen_reg == '0)
        else $error("row end did not restart column and detection");

    a_flush_drain: assert property (@(posedge clk) disable iff (!rst_n)
        fire && row_end && !is_pixel |=> !row_ready_reg && ready_shift_reg == '0)
        else $error("flush at row end left a row ready");

    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && row_end && is_pixel |=> write_bank_reg != $past(write_bank_reg))
        else $error("bank not swapped at end of pixel row");

endmodule

FILE: hdl/rjsc_queue.sv
// short queue between front and back parts
module rjsc_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  rjsc_pkg::q_entry_t             push_entry,
    input  logic                           pop,
    output rjsc_pkg::q_entry_t             head,
    output logic                           not_empty,
    output logic [rjsc_pkg::QCNT_BITS-1:0] count
);
    import rjsc_pkg::*;

    q_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

FILE: hdl/rjsc_back.sv
// back part: tail fill selection and output register
module rjsc_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rjsc_pkg::q_entry_t               head,
    input  logic                             not_empty,
    output logic                             pop,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0] chroma_fill,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             out_valid,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0] plane0_out,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0] plane1_out,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0] plane2_out,
    output logic                             out_last
);
    import rjsc_pkg::*;

    logic                   result_valid_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_last_reg, out_last_next;
    logic [SAMPLE_BITS-1:0] p0_reg, p1_reg, p2_reg;
    logic [SAMPLE_BITS-1:0] p0_next, p1_next, p2_next;

    // take the next entry when the output register is free or moving
    assign pop = not_empty && (!result_valid_reg || result_ready);

    // stored pixel, tail fill, or an empty slot
    always_comb
    begin
        out_valid_next = head.ctrl.px_valid;
        out_last_next  = head.ctrl.px_valid && head.ctrl.last;
        p0_next        = '0;
        p1_next        = '0;
        p2_next        = '0;
        if (head.ctrl.px_valid)
        begin
            if (head.ctrl.from_store)
            begin
                p0_next = head.pix[0 +: SAMPLE_BITS];
                p1_next = head.pix[SAMPLE_BITS +: SAMPLE_BITS];
                p2_next = head.pix[2*SAMPLE_BITS +: SAMPLE_BITS];
            end
            else
            begin
                p1_next = chroma_fill;
                p2_next = chroma_fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            p0_reg        <= p0_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_last     = out_last_reg;
    assign plane0_out   = p0_reg;
    assign plane1_out   = p1_reg;
    assign plane2_out   = p2_reg;

    // checks
    a_last_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && out_last_reg |-> out_valid_reg)
        else $error("row end flagged on an empty slot");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !out_valid_reg |->
            p0_reg == '0 && p1_reg == '0 && p2_reg == '0)
        else $error("empty slot carries sample data");

endmodule

FILE: hdl/row_jitter_shift_corrector.sv
// top level of the row jitter shift corrector
// path: an item passes the line store read register, the queue and the output register
// throughput: one item per cycle while in_ready and result_ready are high;
// new items are taken while fewer than four sit in the store read and queue
// reset: configuration registers return to their defaults, no row is ready; line store
// contents stay undefined and need no clearing pass
module row_jitter_shift_corrector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rjsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rjsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane0_in,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane1_in,
    input  logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane2_in,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                out_valid,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane0_out,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane1_out,
    output logic [rjsc_pkg::SAMPLE_BITS-1:0]    plane2_out,
    output logic                                out_last
);
    import rjsc_pkg::*;

    cfg_t                 cfg_reg;
    logic                 push, pop, q_not_empty;
    q_entry_t             push_entry, q_head;
    logic [QCNT_BITS-1:0] q_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width        <= RST_ROW_WIDTH;
            cfg_reg.max_jitter       <= RST_MAX_JITTER;
            cfg_reg.sync_width       <= RST_SYNC_WIDTH;
            cfg_reg.threshold        <= RST_THRESHOLD;
            cfg_reg.check_all_planes <= 1'b0;
            cfg_reg.chroma_fill      <= RST_CHROMA_FILL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:   cfg_reg.row_width        <= cfg_data[WIDTH_BITS-1:0];
                REG_MAX_JITTER:  cfg_reg.max_jitter       <= cfg_data[JIT_BITS-1:0];
                REG_SYNC_WIDTH:  cfg_reg.sync_width       <= cfg_data[SYNC_BITS-1:0];
                REG_THRESHOLD:   cfg_reg.threshold        <= cfg_data[SAMPLE_BITS-1:0];
                REG_CHECK_ALL:   cfg_reg.check_all_planes <= cfg_data[0];
                REG_CHROMA_FILL: cfg_reg.chroma_fill      <= cfg_data[SAMPLE_BITS-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    rjsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .plane0_in  (plane0_in),
        .plane1_in  (plane1_in),
        .plane2_in  (plane2_in),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    rjsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    rjsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .not_empty    (q_not_empty),
        .pop          (pop),
        .chroma_fill  (cfg_reg.chroma_fill),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_valid    (out_valid),
        .plane0_out   (plane0_out),
        .plane1_out   (plane1_out),
        .plane2_out   (plane2_out),
        .out_last     (out_last)
    );

endmodule
